FILE: sv/aphd_pkg.sv
// package with shared widths and the lane control struct for the hop distance block
`default_nettype none
package aphd_pkg;

  // fixed field widths
  localparam int ROW_W     = 3;
  localparam int BITS_W    = 8;
  localparam int DIST_W    = 4;
  localparam int CNT_W     = 4;
  localparam int OUT_COLS  = 8;

  // reset value of the node count register
  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 4'd8;
  localparam int MAX_NODES_DEFAULT = 8;

  // first walk length found by a matrix product
  localparam logic [DIST_W-1:0] FIRST_PRODUCT_LEN = 4'd2;

  // control that the sequencer hands to every lane
  typedef struct packed {
    logic              load;
    logic              step;
    logic [CNT_W-1:0]  n;
    logic [DIST_W-1:0] r;
  } aphd_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/aphd_lane.sv
// one row lane: holds the reach row and the distance row of one source node
`default_nettype none
module aphd_lane #(
  parameter int MAX_NODES = aphd_pkg::MAX_NODES_DEFAULT
) (
  input  wire logic                                       clk,
  input  wire aphd_pkg::aphd_ctrl_t                       ctrl,
  input  wire logic [MAX_NODES-1:0]                       own_row,
  input  wire logic [MAX_NODES-1:0][MAX_NODES-1:0]        adj,
  output logic      [MAX_NODES-1:0][aphd_pkg::DIST_W-1:0] dist_row
);
  import aphd_pkg::*;

  logic [MAX_NODES-1:0]             reach_r;
  logic [MAX_NODES-1:0]             col_mask;
  logic [MAX_NODES-1:0]             acc;
  logic [MAX_NODES-1:0]             next_row;
  logic [MAX_NODES-1:0][DIST_W-1:0] dist_r;

  // columns in use
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      col_mask[j] = (CNT_W'(j) < ctrl.n);
    end
  end

  // one boolean product row: union of the adjacency rows this row reaches
  always_comb begin
    acc = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      if (reach_r[k]) begin
        acc = acc | adj[k];
      end
    end
    next_row = acc & col_mask;
  end

  // reach and distance registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      reach_r <= own_row & col_mask;
      for (int j = 0; j < MAX_NODES; j++) begin
        dist_r[j] <= own_row[j] ? DIST_W'(1) : DIST_W'(ctrl.n);
      end
    end else if (ctrl.step) begin
      reach_r <= next_row;
      for (int j = 0; j < MAX_NODES; j++) begin
        if (next_row[j] && (dist_r[j] == DIST_W'(ctrl.n))) begin
          dist_r[j] <= ctrl.r;
        end
      end
    end
  end

  assign dist_row = dist_r;

endmodule
`default_nettype wire

FILE: sv/aphd_merge.sv
// merge stage: picks one lane's distances, masks unused columns, registers the result
`default_nettype none
module aphd_merge #(
  parameter int MAX_NODES = aphd_pkg::MAX_NODES_DEFAULT
) (
  input  wire logic                                                        clk,
  input  wire logic                                                        load,
  input  wire logic [$clog2(MAX_NODES)-1:0]                                sel,
  input  wire logic [aphd_pkg::CNT_W-1:0]                                  n,
  input  wire logic                                                        is_final,
  input  wire logic [MAX_NODES-1:0][MAX_NODES-1:0][aphd_pkg::DIST_W-1:0]   dist_all,
  output logic      [aphd_pkg::ROW_W-1:0]                                  row,
  output logic      [aphd_pkg::OUT_COLS-1:0][aphd_pkg::DIST_W-1:0]         dist_out,
  output logic                                                             final_row
);
  import aphd_pkg::*;

  logic [MAX_NODES-1:0][DIST_W-1:0] sel_row;
  logic [OUT_COLS-1:0][DIST_W-1:0]  col_val;
  logic [ROW_W-1:0]                 row_r;
  logic [OUT_COLS-1:0][DIST_W-1:0]  dist_r;
  logic                             final_r;

  // lane select
  assign sel_row = dist_all[sel];

  // columns at or beyond the node count read zero
  for (genvar c = 0; c < OUT_COLS; c++) begin : g_col
    if (c < MAX_NODES) begin : g_used
      assign col_val[c] = (CNT_W'(c) < n) ? sel_row[c] : '0;
    end else begin : g_unused
      assign col_val[c] = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      row_r   <= ROW_W'(sel);
      dist_r  <= col_val;
      final_r <= is_final;
    end
  end

  assign row       = row_r;
  assign dist_out  = dist_r;
  assign final_row = final_r;

endmodule
`default_nettype wire

FILE: sv/all_pairs_hop_distance.sv
// top level of the all-pairs hop distance block: row store, sequencer, lanes and merge
//
// Usage: adjacency rows arrive on the in_ request channel, one per request, with
// in_row_index naming the row and bit j of in_row_bits an edge to node j. A
// request with in_last_row set also stores its row and starts a run over the
// nodes in use (cfg_node_count, clamped to 1..MAX_NODES). The run gives n result
// requests on the out_ channel, rows 0 to n-1, the last marked by out_final_row.
// Operation: a final row first seeds the lanes, then runs one product step per walk
// length from 2 to n-1 (all lanes in parallel), then sends one result row per cycle
// while the receiver takes them.
// in_ready is high only while no run is active; the next request may be taken
// while the last result still waits in the output register. A stalled receiver
// holds the current result and pauses the row sequencer.
// cfg_ready is always high; the user writes the node count while the block is idle, and
// the block does not enforce this. Reset (rst_n low, synchronous) returns to idle,
// empties the output and sets the node count to 8. Row and distance storage is not cleared.
`default_nettype none
module all_pairs_hop_distance #(
  parameter int MAX_NODES = aphd_pkg::MAX_NODES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [aphd_pkg::ROW_W-1:0]    in_row_index,
  input  wire logic [aphd_pkg::BITS_W-1:0]   in_row_bits,
  input  wire logic                          in_last_row,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [aphd_pkg::ROW_W-1:0]    out_row,
  output logic      [aphd_pkg::DIST_W-1:0]   out_dist_to_0,
  output logic      [aphd_pkg::DIST_W-1:0]   out_dist_to_1,
  output logic      [aphd_pkg::DIST_W-1:0]   out_dist_to_2,
  output logic      [aphd_pkg::DIST_W-1:0]   out_dist_to_3,
  output logic      [aphd_pkg::DIST_W-1:0]   out_dist_to_4,
  output logic      [aphd_pkg::DIST_W-1:0]   out_dist_to_5,
  output logic      [aphd_pkg::DIST_W-1:0]   out_dist_to_6,
  output logic      [aphd_pkg::DIST_W-1:0]   out_dist_to_7,
  output logic                               out_final_row,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [aphd_pkg::CNT_W-1:0]    cfg_node_count
);
  import aphd_pkg::*;

  localparam int LIDX_W = $clog2(MAX_NODES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [CNT_W-1:0]                 node_count_r;
  logic [CNT_W-1:0]                 n_r, n_nxt;
  logic [CNT_W-1:0]                 n_clamped;
  logic [DIST_W-1:0]                r_r, r_nxt;
  logic [LIDX_W-1:0]                e_r, e_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [MAX_NODES-1:0][MAX_NODES-1:0] adj_r;
  logic                             in_take;
  logic                             emit_load;
  logic                             emit_final;
  aphd_ctrl_t                       ctrl;
  logic [MAX_NODES-1:0][MAX_NODES-1:0][DIST_W-1:0] dist_all;
  logic [OUT_COLS-1:0][DIST_W-1:0]  dist_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;

  // node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_node_count;
    end
  end

  // clamp to the usable node range
  always_comb begin
    if (node_count_r == '0) begin
      n_clamped = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      n_clamped = CNT_W'(MAX_NODES);
    end else begin
      n_clamped = node_count_r;
    end
  end

  // adjacency row store, rows past the lane count are never used
  always_ff @(posedge clk) begin
    if (in_take && ({1'b0, in_row_index} < (ROW_W + 1)'(MAX_NODES))) begin
      adj_r[in_row_index[LIDX_W-1:0]] <= in_row_bits[MAX_NODES-1:0];
    end
  end

  assign emit_load  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign emit_final = ((CNT_W'(e_r) + CNT_W'(1)) == n_r);

  // run sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    r_nxt         = r_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_take && in_last_row) begin
          state_nxt = ST_INIT;
          n_nxt     = n_clamped;
        end
      end
      ST_INIT: begin
        r_nxt = FIRST_PRODUCT_LEN;
        e_nxt = '0;
        if (n_r <= CNT_W'(2)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (r_r == (n_r - CNT_W'(1))) begin
          state_nxt = ST_EMIT;
        end else begin
          r_nxt = r_r + DIST_W'(1);
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          if (emit_final) begin
            state_nxt = ST_IDLE;
            e_nxt     = '0;
          end else begin
            e_nxt = e_r + LIDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= CNT_W'(MAX_NODES);
      r_r         <= FIRST_PRODUCT_LEN;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      r_r         <= r_nxt;
      e_r         <= e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // lane control
  always_comb begin
    ctrl.load = (state_r == ST_INIT);
    ctrl.step = (state_r == ST_STEP);
    ctrl.n    = n_r;
    ctrl.r    = r_r;
  end

  // one lane per source row
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_lane
    aphd_lane #(
      .MAX_NODES(MAX_NODES)
    ) u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .own_row  (adj_r[i]),
      .adj      (adj_r),
      .dist_row (dist_all[i])
    );
  end

  // merge lanes into the output register
  aphd_merge #(
    .MAX_NODES(MAX_NODES)
  ) u_merge (
    .clk       (clk),
    .load      (emit_load),
    .sel       (e_r),
    .n         (n_r),
    .is_final  (emit_final),
    .dist_all  (dist_all),
    .row       (out_row),
    .dist_out  (dist_out),
    .final_row (out_final_row)
  );

  assign out_valid     = out_valid_r;
  assign out_dist_to_0 = dist_out[0];
  assign out_dist_to_1 = dist_out[1];
  assign out_dist_to_2 = dist_out[2];
  assign out_dist_to_3 = dist_out[3];
  assign out_dist_to_4 = dist_out[4];
  assign out_dist_to_5 = dist_out[5];
  assign out_dist_to_6 = dist_out[6];
  assign out_dist_to_7 = dist_out[7];

  // walk length stays below the node count while stepping
  a_step_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> ((r_r >= FIRST_PRODUCT_LEN) && (r_r < n_r)))
    else $error("walk length out of range during product step");

  // a run starts only from a final row request
  a_init_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> $past(in_valid && in_ready && in_last_row))
    else $error("run started without a final row request");

  // emitted row index stays inside the node count
  a_emit_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (CNT_W'(e_r) < n_r))
    else $error("result row past node count");

  // latched node count is in the usable range
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r != '0) && (n_r <= CNT_W'(MAX_NODES)))
    else $error("node count out of range");

endmodule
`default_nettype wire
